[rtl/snap_point_to_pitch_model_macros.svh]
// assertion macros for the pitch snap block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SNAP_POINT_TO_PITCH_MODEL_MACROS_SVH
`define SNAP_POINT_TO_PITCH_MODEL_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define SPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// expression must never be true out of reset
`define SPP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SPP_ASSERT(lbl, prop, msg)
`define SPP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[rtl/spp_pkg.sv]
// shared constants, types and pitch geometry for the pitch snap block
// no dependencies
`default_nettype none

package spp_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int NUM_SEGS       = 17;
  localparam int NUM_CIRCS      = 3;
  localparam int DIR_EXTRA_BITS = 6;

  localparam int PT_W   = 24;
  localparam int GATE_W = 16;
  localparam int FOOT_W = 15;

  // pitch geometry in centimetres
  localparam int SEG_CM [NUM_SEGS][4] = '{
    '{0, 0, 10500, 0}, '{0, 6800, 10500, 6800}, '{0, 0, 0, 6800},
    '{10500, 0, 10500, 6800}, '{5250, 0, 5250, 6800},
    '{1650, 1384, 1650, 5416}, '{0, 1384, 1650, 1384}, '{0, 5416, 1650, 5416},
    '{8850, 1384, 8850, 5416}, '{10500, 1384, 8850, 1384},
    '{10500, 5416, 8850, 5416},
    '{550, 2484, 550, 4316}, '{0, 2484, 550, 2484}, '{0, 4316, 550, 4316},
    '{9950, 2484, 9950, 4316}, '{10500, 2484, 9950, 2484},
    '{10500, 4316, 9950, 4316}
  };

  localparam int CIRC_CM [NUM_CIRCS][3] = '{
    '{1100, 3400, 915}, '{9400, 3400, 915}, '{5250, 3400, 915}
  };

  // centimetres to fixed point, halves rounded up
  function automatic int cm_to_fx(int cm);
    return (cm * (1 << FRAC_BITS) + 50) / 100;
  endfunction

  function automatic int seg_lo(int s, int axis);
    int a;
    int b;
    a = cm_to_fx(SEG_CM[s][axis]);
    b = cm_to_fx(SEG_CM[s][axis + 2]);
    return (a < b) ? a : b;
  endfunction

  function automatic int seg_hi(int s, int axis);
    int a;
    int b;
    a = cm_to_fx(SEG_CM[s][axis]);
    b = cm_to_fx(SEG_CM[s][axis + 2]);
    return (a < b) ? b : a;
  endfunction

  function automatic int circ_r_max();
    int m;
    m = 0;
    for (int i = 0; i < NUM_CIRCS; i++) begin
      if (cm_to_fx(CIRC_CM[i][2]) > m) m = cm_to_fx(CIRC_CM[i][2]);
    end
    return m;
  endfunction

  localparam int PITCH_X_FX = cm_to_fx(10500);
  localparam int PITCH_Y_FX = cm_to_fx(6800);

  localparam int DIFF_W = PT_W + 1;               // point minus model coordinate
  localparam int SQ_W   = 2 * PT_W;               // one squared difference
  localparam int D_W    = SQ_W + 1;               // squared distance
  localparam int R_W    = $clog2(circ_r_max() + 1);
  localparam int MAG_W  = DIFF_W - 1 + R_W;       // |r * d|
  localparam int N_W    = D_W + 2 * DIR_EXTRA_BITS;
  localparam int NR_W   = N_W + 1;                // root datapath
  localparam int RT_W   = (N_W + 1) / 2;          // root width and step count
  localparam int Q_W    = R_W + 1;                // quotient width and step count
  localparam int REM_W  = RT_W + Q_W;

  localparam longint unsigned SKIP_BELOW =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;

  localparam int SEG_LAT   = 3;
  localparam int SEG_CHAIN = NUM_SEGS * SEG_LAT;
  localparam int CIRC_LAT  = 7 + RT_W + Q_W;
  localparam int TOT_LAT   = SEG_CHAIN + NUM_CIRCS;

  typedef struct packed {
    logic              found;
    logic [FOOT_W-1:0] fx;
    logic [FOOT_W-1:0] fy;
    logic [D_W-1:0]    d;
  } best_t;

  typedef struct packed {
    logic              ok;
    logic [D_W-1:0]    d;
    logic [FOOT_W-1:0] x;
    logic [FOOT_W-1:0] y;
  } cand_t;

endpackage

`default_nettype wire

[rtl/spp_pick.sv]
// compare stage: keeps the running nearest foot against one candidate
// depends on spp_pkg
`default_nettype none

module spp_pick import spp_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  best_t best_i,
  input  cand_t cand_i,
  output best_t best_o
);

  best_t best_d, best_q;

  // strict less keeps the earlier primitive on a tie
  always_comb begin
    best_d = best_i;
    if (cand_i.ok && (cand_i.d < best_i.d)) begin
      best_d.found = 1'b1;
      best_d.fx    = cand_i.x;
      best_d.fy    = cand_i.y;
      best_d.d     = cand_i.d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) best_q <= best_d;
  end

  assign best_o = best_q;

endmodule

`default_nettype wire

[rtl/spp_seg_cell.sv]
// one segment cell: clamp, square, compare, three register levels
// depends on spp_pkg and spp_pick
`default_nettype none

module spp_seg_cell import spp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [PT_W-1:0]   qx_i,
  input  logic signed [PT_W-1:0]   qy_i,
  input  best_t                    best_i,
  input  logic        [FOOT_W-1:0] xlo_i,
  input  logic        [FOOT_W-1:0] xhi_i,
  input  logic        [FOOT_W-1:0] ylo_i,
  input  logic        [FOOT_W-1:0] yhi_i,
  output logic signed [PT_W-1:0]   qx_o,
  output logic signed [PT_W-1:0]   qy_o,
  output best_t                    best_o
);

  function automatic logic [FOOT_W-1:0] clamp_span(logic signed [PT_W-1:0] v,
                                                   logic [FOOT_W-1:0] lo,
                                                   logic [FOOT_W-1:0] hi);
    logic signed [PT_W-1:0] lo_s;
    logic signed [PT_W-1:0] hi_s;
    logic        [FOOT_W-1:0] r;
    lo_s = PT_W'(lo);
    hi_s = PT_W'(hi);
    if (v < lo_s) r = lo;
    else if (v > hi_s) r = hi;
    else r = v[FOOT_W-1:0];
    return r;
  endfunction

  logic        [FOOT_W-1:0]   px_d, py_d;
  logic signed [DIFF_W-1:0]   dx_d, dy_d;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;

  logic        [FOOT_W-1:0]   px1_q, py1_q, px2_q, py2_q;
  logic signed [DIFF_W-1:0]   dx1_q, dy1_q;
  logic        [SQ_W-1:0]     sx2_q, sy2_q;
  logic signed [PT_W-1:0]     qx1_q, qy1_q, qx2_q, qy2_q, qx3_q, qy3_q;
  best_t                      best1_q, best2_q;
  cand_t                      cand;

  assign px_d = clamp_span(qx_i, xlo_i, xhi_i);
  assign py_d = clamp_span(qy_i, ylo_i, yhi_i);
  assign dx_d = DIFF_W'(qx_i) - DIFF_W'(px_d);
  assign dy_d = DIFF_W'(qy_i) - DIFF_W'(py_d);

  assign sqx_full = dx1_q * dx1_q;
  assign sqy_full = dy1_q * dy1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px1_q   <= px_d;
      py1_q   <= py_d;
      dx1_q   <= dx_d;
      dy1_q   <= dy_d;
      qx1_q   <= qx_i;
      qy1_q   <= qy_i;
      best1_q <= best_i;
      px2_q   <= px1_q;
      py2_q   <= py1_q;
      sx2_q   <= sqx_full[SQ_W-1:0];
      sy2_q   <= sqy_full[SQ_W-1:0];
      qx2_q   <= qx1_q;
      qy2_q   <= qy1_q;
      best2_q <= best1_q;
      qx3_q   <= qx2_q;
      qy3_q   <= qy2_q;
    end
  end

  assign cand.ok = 1'b1;
  assign cand.d  = D_W'(sx2_q) + D_W'(sy2_q);
  assign cand.x  = px2_q;
  assign cand.y  = py2_q;

  spp_pick u_pick (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .best_i (best2_q),
    .cand_i (cand),
    .best_o (best_o)
  );

  assign qx_o = qx3_q;
  assign qy_o = qy3_q;

endmodule

`default_nettype wire

[rtl/spp_sqrt_cell.sv]
// one digit of the integer square root, registered
// depends on spp_pkg
`default_nettype none

module spp_sqrt_cell import spp_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NR_W-1:0] n_i,
  input  logic [NR_W-1:0] res_i,
  input  logic [NR_W-1:0] msk_i,
  output logic [NR_W-1:0] n_o,
  output logic [NR_W-1:0] res_o,
  output logic [NR_W-1:0] msk_o
);

  logic [NR_W-1:0] trial;
  logic [NR_W-1:0] n_d, res_d;
  logic [NR_W-1:0] n_q, res_q, msk_q;

  assign trial = res_i + msk_i;

  always_comb begin
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + msk_i;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      res_q <= res_d;
      msk_q <= msk_i >> 2;
    end
  end

  assign n_o   = n_q;
  assign res_o = res_q;
  assign msk_o = msk_q;

endmodule

`default_nettype wire

[rtl/spp_div_cell.sv]
// one quotient bit of a restoring divider, registered
// depends on spp_pkg
`default_nettype none

module spp_div_cell import spp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [REM_W-1:0] dsh_i,
  input  logic [Q_W-1:0]   q_i,
  output logic [REM_W-1:0] rem_o,
  output logic [REM_W-1:0] dsh_o,
  output logic [Q_W-1:0]   q_o
);

  logic [REM_W-1:0] rem_d, rem_q, dsh_q;
  logic [Q_W-1:0]   q_d, q_q;

  always_comb begin
    if (rem_i >= dsh_i) begin
      rem_d = rem_i - dsh_i;
      q_d   = {q_i[Q_W-2:0], 1'b1};
    end else begin
      rem_d = rem_i;
      q_d   = {q_i[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dsh_q <= dsh_i >> 1;
      q_q   <= q_d;
    end
  end

  assign rem_o = rem_q;
  assign dsh_o = dsh_q;
  assign q_o   = q_q;

endmodule

`default_nettype wire

[rtl/spp_circ.sv]
// radial projection onto one circle: root and divider chains, then distance
// depends on spp_pkg, spp_sqrt_cell and spp_div_cell
`default_nettype none

module spp_circ import spp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [PT_W-1:0]   qx_i,
  input  logic signed [PT_W-1:0]   qy_i,
  input  logic        [FOOT_W-1:0] cx_i,
  input  logic        [FOOT_W-1:0] cy_i,
  input  logic        [R_W-1:0]    r_i,
  output cand_t                    cand_o
);

  localparam int SIDE_LEN = RT_W + 1 + Q_W;

  typedef struct packed {
    logic signed [PT_W-1:0] qx;
    logic signed [PT_W-1:0] qy;
    logic                   sgx;
    logic                   sgy;
    logic [MAG_W-1:0]       mx;
    logic [MAG_W-1:0]       my;
    logic                   skip;
  } side_t;

  // offset from centre
  logic signed [DIFF_W-1:0]   dx1_q, dy1_q;
  logic signed [PT_W-1:0]     qx1_q, qy1_q;
  // squares and radius products
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
  logic        [DIFF_W-1:0]   ax_d, ay_d;
  logic        [SQ_W-1:0]     sx2_q, sy2_q;
  logic        [MAG_W-1:0]    mx2_q, my2_q;
  logic                       sgx2_q, sgy2_q;
  logic signed [PT_W-1:0]     qx2_q, qy2_q;
  // radicand and side line
  logic        [D_W-1:0]      s_d;
  logic        [NR_W-1:0]     n_q;
  side_t                      side_d;
  side_t                      sd_q [SIDE_LEN+1];

  assign sqx_full = dx1_q * dx1_q;
  assign sqy_full = dy1_q * dy1_q;
  assign ax_d = dx1_q[DIFF_W-1] ? DIFF_W'(-dx1_q) : DIFF_W'(dx1_q);
  assign ay_d = dy1_q[DIFF_W-1] ? DIFF_W'(-dy1_q) : DIFF_W'(dy1_q);
  assign s_d  = D_W'(sx2_q) + D_W'(sy2_q);

  assign side_d.qx   = qx2_q;
  assign side_d.qy   = qy2_q;
  assign side_d.sgx  = sgx2_q;
  assign side_d.sgy  = sgy2_q;
  assign side_d.mx   = mx2_q;
  assign side_d.my   = my2_q;
  assign side_d.skip = (s_d < D_W'(SKIP_BELOW));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q  <= DIFF_W'(qx_i) - DIFF_W'(cx_i);
      dy1_q  <= DIFF_W'(qy_i) - DIFF_W'(cy_i);
      qx1_q  <= qx_i;
      qy1_q  <= qy_i;
      sx2_q  <= sqx_full[SQ_W-1:0];
      sy2_q  <= sqy_full[SQ_W-1:0];
      mx2_q  <= MAG_W'(ax_d[DIFF_W-2:0]) * MAG_W'(r_i);
      my2_q  <= MAG_W'(ay_d[DIFF_W-2:0]) * MAG_W'(r_i);
      sgx2_q <= dx1_q[DIFF_W-1];
      sgy2_q <= dy1_q[DIFF_W-1];
      qx2_q  <= qx1_q;
      qy2_q  <= qy1_q;
      n_q    <= NR_W'({s_d, {(2*DIR_EXTRA_BITS){1'b0}}});
      sd_q[0] <= side_d;
      for (int k = 1; k <= SIDE_LEN; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // root chain, one result bit per cell
  logic [NR_W-1:0] n_c   [RT_W+1];
  logic [NR_W-1:0] res_c [RT_W+1];
  logic [NR_W-1:0] msk_c [RT_W+1];

  assign n_c[0]   = n_q;
  assign res_c[0] = '0;
  assign msk_c[0] = NR_W'(1) << (2 * (RT_W - 1));

  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    spp_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .n_i   (n_c[k]),
      .res_i (res_c[k]),
      .msk_i (msk_c[k]),
      .n_o   (n_c[k+1]),
      .res_o (res_c[k+1]),
      .msk_o (msk_c[k+1])
    );
  end

  logic [RT_W-1:0] dq;
  assign dq = res_c[RT_W][RT_W-1:0];

  // divider setup: rounded magnitude over the scaled length
  logic [REM_W-1:0] xr_c [Q_W+1];
  logic [REM_W-1:0] xd_c [Q_W+1];
  logic [Q_W-1:0]   xq_c [Q_W+1];
  logic [REM_W-1:0] yr_c [Q_W+1];
  logic [REM_W-1:0] yd_c [Q_W+1];
  logic [Q_W-1:0]   yq_c [Q_W+1];
  logic [REM_W-1:0] xr0_q, yr0_q, dsh0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xr0_q  <= REM_W'({sd_q[RT_W].mx, {DIR_EXTRA_BITS{1'b0}}}) + REM_W'(dq >> 1);
      yr0_q  <= REM_W'({sd_q[RT_W].my, {DIR_EXTRA_BITS{1'b0}}}) + REM_W'(dq >> 1);
      dsh0_q <= REM_W'(dq) << (Q_W - 1);
    end
  end

  assign xr_c[0] = xr0_q;
  assign xd_c[0] = dsh0_q;
  assign xq_c[0] = '0;
  assign yr_c[0] = yr0_q;
  assign yd_c[0] = dsh0_q;
  assign yq_c[0] = '0;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    spp_div_cell u_xcell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (xr_c[k]),
      .dsh_i (xd_c[k]),
      .q_i   (xq_c[k]),
      .rem_o (xr_c[k+1]),
      .dsh_o (xd_c[k+1]),
      .q_o   (xq_c[k+1])
    );
    spp_div_cell u_ycell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (yr_c[k]),
      .dsh_i (yd_c[k]),
      .q_i   (yq_c[k]),
      .rem_o (yr_c[k+1]),
      .dsh_o (yd_c[k+1]),
      .q_o   (yq_c[k+1])
    );
  end

  // foot, then squared distance back to the point
  side_t                      sf;
  logic        [FOOT_W-1:0]   px_d, py_d;
  logic        [FOOT_W-1:0]   pxf_q, pyf_q, pxe_q, pye_q;
  logic signed [DIFF_W-1:0]   exf_q, eyf_q;
  logic signed [2*DIFF_W-1:0] sex_full, sey_full;
  logic        [SQ_W-1:0]     sxe_q, sye_q;
  logic                       skf_q, ske_q;
  cand_t                      cand_q;

  assign sf   = sd_q[SIDE_LEN];
  assign px_d = sf.sgx ? cx_i - FOOT_W'(xq_c[Q_W]) : cx_i + FOOT_W'(xq_c[Q_W]);
  assign py_d = sf.sgy ? cy_i - FOOT_W'(yq_c[Q_W]) : cy_i + FOOT_W'(yq_c[Q_W]);
  assign sex_full = exf_q * exf_q;
  assign sey_full = eyf_q * eyf_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxf_q     <= px_d;
      pyf_q     <= py_d;
      exf_q     <= DIFF_W'(sf.qx) - DIFF_W'(px_d);
      eyf_q     <= DIFF_W'(sf.qy) - DIFF_W'(py_d);
      skf_q     <= sf.skip;
      pxe_q     <= pxf_q;
      pye_q     <= pyf_q;
      sxe_q     <= sex_full[SQ_W-1:0];
      sye_q     <= sey_full[SQ_W-1:0];
      ske_q     <= skf_q;
      cand_q.ok <= !ske_q;
      cand_q.d  <= D_W'(sxe_q) + D_W'(sye_q);
      cand_q.x  <= pxe_q;
      cand_q.y  <= pye_q;
    end
  end

  assign cand_o = cand_q;

endmodule

`default_nettype wire

[rtl/snap_point_to_pitch_model.sv]
// top level of the pitch snap block: segment cell chain, circle units, final picks
// depends on spp_pkg, spp_seg_cell, spp_circ, spp_pick and the macros header
`default_nettype none

// Snaps a pitch-plane point (signed Q15.8 metres) to the nearest line of a
// 105 m by 68 m pitch model: 17 axis-aligned segments with the foot clamped
// to the segment, then 3 circles with a radial foot (a circle is ignored when
// the point is within 1 mm of its centre). The nearest foot strictly closer
// than the gate wins, the earliest primitive on a tie, segments first. With
// no hit, found and both foot coordinates are zero. One word is taken every
// cycle unless the pipeline holds. Its depth is set by the row of 17 segment
// cells, three register levels each, which runs alongside the circle units
// (offset, square and radicand registers, a 31-cell square root chain, a
// divider setup register, a 13-cell restoring divider per axis, then foot,
// square and distance registers), followed by one compare stage per circle.
// The whole pipeline advances together and only holds while a finished word
// waits at the output with out_stall_i high.

`include "snap_point_to_pitch_model_macros.svh"

module snap_point_to_pitch_model import spp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input word
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [PT_W-1:0]   point_x_i,
  input  logic signed [PT_W-1:0]   point_y_i,
  input  logic        [GATE_W-1:0] gate_i,
  // result word
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic        [FOOT_W-1:0] foot_x_o,
  output logic        [FOOT_W-1:0] foot_y_o
);

  // pipeline advance: everything moves unless the result word is held
  logic               en;
  logic [TOT_LAT-1:0] vld_q;

  assign en         = !(vld_q[TOT_LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT_LAT-2:0], in_valid_i};
    end
  end

  // gate squared is the starting bound, nothing found yet
  logic [2*GATE_W-1:0] gate_sq;
  assign gate_sq = gate_i * gate_i;

  // segment cell row, each cell hands point and running best to the next
  logic signed [PT_W-1:0] sqx [NUM_SEGS];
  logic signed [PT_W-1:0] sqy [NUM_SEGS];
  best_t                  sbest [NUM_SEGS+1];

  assign sqx[0]         = point_x_i;
  assign sqy[0]         = point_y_i;
  assign sbest[0].found = 1'b0;
  assign sbest[0].fx    = '0;
  assign sbest[0].fy    = '0;
  assign sbest[0].d     = D_W'(gate_sq);

  for (genvar k = 0; k < NUM_SEGS; k++) begin : g_seg
    if (k < NUM_SEGS - 1) begin : g_mid
      spp_seg_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .qx_i   (sqx[k]),
        .qy_i   (sqy[k]),
        .best_i (sbest[k]),
        .xlo_i  (FOOT_W'(seg_lo(k, 0))),
        .xhi_i  (FOOT_W'(seg_hi(k, 0))),
        .ylo_i  (FOOT_W'(seg_lo(k, 1))),
        .yhi_i  (FOOT_W'(seg_hi(k, 1))),
        .qx_o   (sqx[k+1]),
        .qy_o   (sqy[k+1]),
        .best_o (sbest[k+1])
      );
    end else begin : g_last
      // point is no longer needed after the last segment
      spp_seg_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .qx_i   (sqx[k]),
        .qy_i   (sqy[k]),
        .best_i (sbest[k]),
        .xlo_i  (FOOT_W'(seg_lo(k, 0))),
        .xhi_i  (FOOT_W'(seg_hi(k, 0))),
        .ylo_i  (FOOT_W'(seg_lo(k, 1))),
        .yhi_i  (FOOT_W'(seg_hi(k, 1))),
        .qx_o   (),
        .qy_o   (),
        .best_o (sbest[k+1])
      );
    end
  end

  // circle units start with the segment row and line up with its end
  cand_t cand_c [NUM_CIRCS];
  cand_t cand_a [NUM_CIRCS];

  for (genvar i = 0; i < NUM_CIRCS; i++) begin : g_circ
    localparam int DLY = SEG_CHAIN - CIRC_LAT + i;

    spp_circ u_circ (
      .clk_i  (clk_i),
      .en_i   (en),
      .qx_i   (point_x_i),
      .qy_i   (point_y_i),
      .cx_i   (FOOT_W'(cm_to_fx(CIRC_CM[i][0]))),
      .cy_i   (FOOT_W'(cm_to_fx(CIRC_CM[i][1]))),
      .r_i    (R_W'(cm_to_fx(CIRC_CM[i][2]))),
      .cand_o (cand_c[i])
    );

    // each later circle meets the best one compare stage further on
    if (DLY == 0) begin : g_nodly
      assign cand_a[i] = cand_c[i];
    end else begin : g_dly
      cand_t dly_q [DLY];
      always_ff @(posedge clk_i) begin
        if (en) begin
          dly_q[0] <= cand_c[i];
          for (int k = 1; k < DLY; k++) dly_q[k] <= dly_q[k-1];
        end
      end
      assign cand_a[i] = dly_q[DLY-1];
    end
  end

  // circle compares in table order
  best_t pbest [NUM_CIRCS+1];
  assign pbest[0] = sbest[NUM_SEGS];

  for (genvar i = 0; i < NUM_CIRCS; i++) begin : g_pick
    spp_pick u_pick (
      .clk_i  (clk_i),
      .en_i   (en),
      .best_i (pbest[i]),
      .cand_i (cand_a[i]),
      .best_o (pbest[i+1])
    );
  end

  // foot stays at its zero start value when nothing was found
  assign out_valid_o = vld_q[TOT_LAT-1];
  assign found_o     = pbest[NUM_CIRCS].found;
  assign foot_x_o    = pbest[NUM_CIRCS].fx;
  assign foot_y_o    = pbest[NUM_CIRCS].fy;

  `SPP_ASSERT(a_miss_zero, out_valid_o && !found_o |-> foot_x_o == '0 && foot_y_o == '0, "miss with nonzero foot")
  `SPP_ASSERT(a_foot_on_pitch, out_valid_o && found_o |-> foot_x_o <= FOOT_W'(PITCH_X_FX) && foot_y_o <= FOOT_W'(PITCH_Y_FX), "foot off the pitch")
  `SPP_ASSERT_NEVER(a_stall_cause, in_stall_o && !out_valid_o, "input stalled with no held result")

endmodule

`default_nettype wire

[verif/tb_snap_point_to_pitch_model.sv]
// self-checking testbench for snap_point_to_pitch_model: drives point words, checks snapped feet
// depends on spp_pkg for port widths and on the snap_point_to_pitch_model rtl
`default_nettype none

module tb_snap_point_to_pitch_model import spp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QFRAC      = 8;
  localparam int ROOT_XTRA  = 6;
  localparam int CYCLE_MAX  = 600000;
  localparam int DRAIN_WAIT = 80;
  localparam int N_RANDOM   = 1600;

  // pitch lines in centimetres: x0, y0, x1, y1
  localparam int LINE_CM [17][4] = '{
    '{0, 0, 10500, 0}, '{0, 6800, 10500, 6800}, '{0, 0, 0, 6800},
    '{10500, 0, 10500, 6800}, '{5250, 0, 5250, 6800},
    '{1650, 1384, 1650, 5416}, '{0, 1384, 1650, 1384}, '{0, 5416, 1650, 5416},
    '{8850, 1384, 8850, 5416}, '{10500, 1384, 8850, 1384},
    '{10500, 5416, 8850, 5416},
    '{550, 2484, 550, 4316}, '{0, 2484, 550, 2484}, '{0, 4316, 550, 4316},
    '{9950, 2484, 9950, 4316}, '{10500, 2484, 9950, 2484},
    '{10500, 4316, 9950, 4316}
  };
  // arcs and centre circle in centimetres: cx, cy, radius
  localparam int ARC_CM [3][3] = '{
    '{1100, 3400, 915}, '{9400, 3400, 915}, '{5250, 3400, 915}
  };

  typedef struct {
    bit              found;
    bit [FOOT_W-1:0] fx;
    bit [FOOT_W-1:0] fy;
  } snap_t;

  // scoreboard: computes the snapped foot of each accepted point and checks results in order
  class snap_scoreboard;
    snap_t pending_feet[$];
    int    n_bad;
    int    n_checked;
    int    n_hits;

    function automatic longint to_fx(int cm);
      return ((longint'(cm) << QFRAC) + 50) / 100;
    endfunction

    function automatic longint clip(longint v, longint a, longint b);
      longint lo;
      longint hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // rounded division, halves away from zero
    function automatic longint div_round(longint num, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic snap_t snap_point(longint qx, longint qy, longint g);
      snap_t r;
      longint unsigned best;
      longint unsigned d;
      longint unsigned s;
      longint unsigned dq;
      longint unsigned skip_lim;
      longint px, py, cx, cy, rad, dx, dy;
      best = g * g;
      skip_lim = ((64'd1 << (2 * QFRAC)) + 64'd999999) / 64'd1000000;
      r = '{1'b0, '0, '0};
      for (int i = 0; i < 17; i++) begin
        px = clip(qx, to_fx(LINE_CM[i][0]), to_fx(LINE_CM[i][2]));
        py = clip(qy, to_fx(LINE_CM[i][1]), to_fx(LINE_CM[i][3]));
        d = (qx - px) * (qx - px) + (qy - py) * (qy - py);
        if (d < best) begin
          best = d;
          r = '{1'b1, px[FOOT_W-1:0], py[FOOT_W-1:0]};
        end
      end
      for (int i = 0; i < 3; i++) begin
        cx = to_fx(ARC_CM[i][0]);
        cy = to_fx(ARC_CM[i][1]);
        rad = to_fx(ARC_CM[i][2]);
        dx = qx - cx;
        dy = qy - cy;
        s = dx * dx + dy * dy;
        if (s >= skip_lim) begin
          dq = int_sqrt(s << (2 * ROOT_XTRA));
          px = cx + div_round(rad * dx * (64'sd1 << ROOT_XTRA), dq);
          py = cy + div_round(rad * dy * (64'sd1 << ROOT_XTRA), dq);
          d = (qx - px) * (qx - px) + (qy - py) * (qy - py);
          if (d < best) begin
            best = d;
            r = '{1'b1, px[FOOT_W-1:0], py[FOOT_W-1:0]};
          end
        end
      end
      return r;
    endfunction

    function void note_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                             logic [GATE_W-1:0] g);
      pending_feet.insert(pending_feet.size(),
                          snap_point(longint'(x), longint'(y), longint'(g)));
    endfunction

    function void check_result(logic f, logic [FOOT_W-1:0] fx, logic [FOOT_W-1:0] fy);
      snap_t e;
      n_checked++;
      if (pending_feet.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word: found=%0d x=%0d y=%0d", f, fx, fy);
        return;
      end
      e = pending_feet.pop_front();
      if (e.found) n_hits++;
      if (f !== e.found || fx !== e.fx || fy !== e.fy) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch on word %0d: expected found=%0d x=%0d y=%0d, got found=%0d x=%0d y=%0d",
                   n_checked, e.found, e.fx, e.fy, f, fx, fy);
      end
    endfunction

    function int pending();
      return pending_feet.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [PT_W-1:0]   point_x_i;
  logic signed [PT_W-1:0]   point_y_i;
  logic        [GATE_W-1:0] gate_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     found_o;
  logic        [FOOT_W-1:0] foot_x_o;
  logic        [FOOT_W-1:0] foot_y_o;

  snap_scoreboard sb = new();

  // idle rates in percent for each side, changed per phase
  int tx_idle_pct;
  int rx_idle_pct;
  // long receiver hold-off: requested by the stimulus, counted down by the receiver
  int hold_req;
  int hold_left;
  int n_sent;

  snap_point_to_pitch_model u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .gate_i      (gate_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .foot_x_o    (foot_x_o),
    .foot_y_o    (foot_y_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on total run length
  int cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: check accepted words, then pick the stall for the next edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(found_o, foot_x_o, foot_y_o);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // offer one word and hold it until taken, with a random idle gap before it
  task automatic send_word(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                           logic [GATE_W-1:0] g);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    gate_i     <= g;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(x, y, g);
    n_sent++;
  endtask

  // sender stops offering until every result has come back
  task automatic drain_out();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // metres in Q8 from centimetres, for directed points
  function automatic logic signed [PT_W-1:0] cm(int c);
    return PT_W'((c * 256 + 50) / 100);
  endfunction

  // random word: mostly points around the pitch, some across the whole range
  task automatic send_random();
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic [GATE_W-1:0]      g;
    int                     sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      x = PT_W'(int'($urandom_range(32000)) - 2600);
      y = PT_W'(int'($urandom_range(22400)) - 2600);
    end else if (sel < 88) begin
      // near a circle centre
      x = cm(ARC_CM[sel % 3][0]) + PT_W'(int'($urandom_range(8)) - 4);
      y = cm(3400) + PT_W'(int'($urandom_range(8)) - 4);
    end else begin
      x = PT_W'($urandom);
      y = PT_W'($urandom);
    end
    sel = $urandom_range(9);
    if (sel < 6)      g = GATE_W'($urandom_range(1024));
    else if (sel < 9) g = GATE_W'($urandom);
    else              g = GATE_W'($urandom_range(3));
    send_word(x, y, g);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    out_stall_i <= 1'b0;
    point_x_i   <= '0;
    point_y_i   <= '0;
    gate_i      <= '0;
    tx_idle_pct = 17;
    rx_idle_pct = 45;
    hold_req    = 0;
    hold_left   = 0;
    n_sent      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes
    send_word(-24'sd8388608, -24'sd8388608, 16'hFFFF);
    send_word(24'sd8388607, 24'sd8388607, 16'hFFFF);
    send_word(-24'sd8388608, 24'sd8388607, 16'h0000);
    send_word(24'sd8388607, -24'sd8388608, 16'h8000);
    // zero gate never snaps, gate of one lsb needs an exact hit
    send_word(cm(5250), cm(0), 16'd0);
    send_word(cm(5250), cm(0), 16'd1);
    send_word(cm(5250), cm(100), 16'd1);
    // exactly on a circle centre (skipped) and one lsb off it
    send_word(cm(1100), cm(3400), 16'hFFFF);
    send_word(cm(5250), cm(3400), 16'd3000);
    send_word(cm(9400) + 24'sd1, cm(3400), 16'd3000);
    send_word(cm(5250), cm(3400) - 24'sd1, 16'd3000);
    // ties: equidistant from two lines, corner points, penalty box corner
    send_word(cm(5250 / 2), cm(6800 / 2), 16'hFFFF);
    send_word(cm(0), cm(0), 16'd100);
    send_word(cm(10500), cm(6800), 16'd100);
    send_word(cm(1650), cm(1384), 16'd50);
    send_word(cm(275), cm(2484) + 24'sd10, 16'd512);
    // beyond the touchlines, and on a circle's rim
    send_word(-cm(500), cm(3400), 16'd2000);
    send_word(cm(11000), cm(7500), 16'd4000);
    send_word(cm(5250 + 915), cm(3400), 16'd200);
    send_word(cm(5250 + 600), cm(3400 + 600), 16'd512);
    send_word(cm(1100 + 800), cm(3400 - 400), 16'd512);

    // receiver holds off long enough to fill the pipeline and back up the input
    hold_req = 200;
    for (int i = 0; i < N_RANDOM / 3; i++) send_random();
    drain_out();

    tx_idle_pct = 45;
    rx_idle_pct = 17;
    for (int i = 0; i < N_RANDOM / 3; i++) send_random();
    drain_out();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < N_RANDOM / 3; i++) send_random();
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d point words, checked %0d results, %0d of them snapped",
             n_sent, sb.n_checked, sb.n_hits);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.n_bad, sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
